/* rtl/phcf_pkg.sv */
// ----------------------------------------------------------------------------
// phcf_pkg: shared definitions for the pixel hit cluster framer
// Mode codes, register indexes, stream byte codes and the command record
// handed from the front end to the byte emitter.
// ----------------------------------------------------------------------------
package phcf_pkg;

  // input transaction modes
  localparam logic [2:0] MODE_HIT      = 3'd0;
  localparam logic [2:0] MODE_EOF      = 3'd1;
  localparam logic [2:0] MODE_BUSY_ON  = 3'd2;
  localparam logic [2:0] MODE_BUSY_OFF = 3'd3;
  localparam logic [2:0] MODE_IDLE     = 3'd4;

  // configuration register indexes
  localparam logic REG_CHIP_ID      = 1'b0;
  localparam logic REG_INNER_BARREL = 1'b1;

  // stream byte codes
  localparam logic [7:0] BYTE_CHIP_HDR  = 8'hA0;
  localparam logic [7:0] BYTE_TRAILER   = 8'hB0;
  localparam logic [7:0] BYTE_REGION    = 8'hC0;
  localparam logic [7:0] BYTE_EMPTY     = 8'hE0;
  localparam logic [7:0] BYTE_SHORT     = 8'h40;
  localparam logic [7:0] BYTE_IDLE      = 8'hFF;
  localparam logic [7:0] BYTE_BUSY_ON   = 8'hF1;
  localparam logic [7:0] BYTE_BUSY_OFF  = 8'hF0;
  localparam logic [5:0] POS_HI_MASK    = 6'h3F;
  localparam logic [7:0] BYTE_LONG_FLAG = 8'h80;

  // most bytes one transaction can produce: flush(3) + chip hdr(3) + region hdr(3)
  localparam int CMD_BYTES = 9;
  localparam int CNT_W     = $clog2(CMD_BYTES + 1);

  // command queue depth
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [CMD_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          cnt;
  } cmd_t;

endpackage

/* rtl/phcf_front.sv */
// ----------------------------------------------------------------------------
// phcf_front: frame and cluster tracking
// Accepts input transactions, updates frame/cluster state and builds the
// byte list each transaction releases.
// ----------------------------------------------------------------------------
module phcf_front import phcf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [3:0]  chip_id,
  input  logic        inner_barrel,
  input  logic        accept,
  input  logic [2:0]  mode,
  input  logic [4:0]  region_id,
  input  logic [13:0] hit_position,
  input  logic [7:0]  timestamp,
  input  logic [3:0]  trailer_flags,
  output cmd_t        cmd
);

  logic        frame_open_r,  frame_open_nxt;
  logic        chip_sent_r,   chip_sent_nxt;
  logic        region_sent_r, region_sent_nxt;
  logic [4:0]  cur_region_r,  cur_region_nxt;
  logic        clu_valid_r,   clu_valid_nxt;
  logic [13:0] clu_base_r,    clu_base_nxt;
  logic [6:0]  clu_map_r,     clu_map_nxt;
  logic [7:0]  frame_ts_r,    frame_ts_nxt;

  logic [2:0]  top_off;
  logic [14:0] clu_top;
  logic [13:0] pos_diff;

  // offset of the highest hit in the open cluster: lowest set map bit
  always_comb begin
    top_off = 3'd0;
    for (int i = 6; i >= 0; i--) begin
      if (clu_map_r[i]) top_off = 3'(7 - i);
    end
    clu_top  = {1'b0, clu_base_r} + {12'd0, top_off};
    pos_diff = hit_position - clu_base_r;
  end

  always_comb begin
    logic             fo, chs, rhs, cv;
    logic [4:0]       cr;
    logic [7:0]       ts_v;
    logic             drop, join_hit;
    logic [CNT_W-1:0] n;
    logic [CMD_BYTES-1:0][7:0] b;

    frame_open_nxt  = frame_open_r;
    chip_sent_nxt   = chip_sent_r;
    region_sent_nxt = region_sent_r;
    cur_region_nxt  = cur_region_r;
    clu_valid_nxt   = clu_valid_r;
    clu_base_nxt    = clu_base_r;
    clu_map_nxt     = clu_map_r;
    frame_ts_nxt    = frame_ts_r;

    fo       = frame_open_r;
    chs      = chip_sent_r;
    rhs      = region_sent_r;
    cv       = clu_valid_r;
    cr       = cur_region_r;
    ts_v     = frame_ts_r;
    drop     = 1'b0;
    join_hit = 1'b0;
    n        = '0;
    b        = '0;

    // a hit or end of frame opens a closed frame with fresh state
    if ((mode == MODE_HIT || mode == MODE_EOF) && !fo) begin
      chs  = 1'b0;
      rhs  = 1'b0;
      cv   = 1'b0;
      cr   = 5'd0;
      ts_v = timestamp;
    end

    unique case (mode)
      MODE_HIT: begin
        if (frame_open_r && clu_valid_r) begin
          if (region_id < cur_region_r) begin
            drop = 1'b1;
          end else if (region_id == cur_region_r && {1'b0, hit_position} <= clu_top) begin
            drop = 1'b1;
          end else if (region_id == cur_region_r &&
                       {1'b0, hit_position} < {1'b0, clu_base_r} + 15'd8) begin
            join_hit = 1'b1;
          end
        end

        if (join_hit) begin
          clu_map_nxt = clu_map_r | (7'd1 << (3'd7 - pos_diff[2:0]));
        end else if (!drop) begin
          if (cv) begin
            if (clu_map_r == 7'd0) begin
              b[n] = BYTE_SHORT | {2'b00, clu_base_r[13:8] & POS_HI_MASK}; n = n + 1'b1;
              b[n] = clu_base_r[7:0]; n = n + 1'b1;
              if (inner_barrel) begin
                b[n] = BYTE_IDLE; n = n + 1'b1;
              end
            end else begin
              b[n] = {2'b00, clu_base_r[13:8]}; n = n + 1'b1;
              b[n] = clu_base_r[7:0]; n = n + 1'b1;
              b[n] = {1'b0, clu_map_r}; n = n + 1'b1;
            end
          end
          if (!chs) begin
            b[n] = BYTE_CHIP_HDR | {4'h0, chip_id}; n = n + 1'b1;
            b[n] = ts_v; n = n + 1'b1;
            if (inner_barrel) begin
              b[n] = BYTE_IDLE; n = n + 1'b1;
            end
            rhs = 1'b0;
          end
          if (!rhs || region_id != cr) begin
            b[n] = BYTE_REGION | {3'b000, region_id}; n = n + 1'b1;
            if (inner_barrel) begin
              b[n] = BYTE_IDLE; n = n + 1'b1;
              b[n] = BYTE_IDLE; n = n + 1'b1;
            end
            cr = region_id;
          end
          frame_open_nxt  = 1'b1;
          chip_sent_nxt   = 1'b1;
          region_sent_nxt = 1'b1;
          cur_region_nxt  = cr;
          clu_valid_nxt   = 1'b1;
          clu_base_nxt    = hit_position;
          clu_map_nxt     = 7'd0;
          frame_ts_nxt    = ts_v;
        end
      end
      MODE_EOF: begin
        if (chs) begin
          if (cv) begin
            if (clu_map_r == 7'd0) begin
              b[n] = BYTE_SHORT | {2'b00, clu_base_r[13:8] & POS_HI_MASK}; n = n + 1'b1;
              b[n] = clu_base_r[7:0]; n = n + 1'b1;
              if (inner_barrel) begin
                b[n] = BYTE_IDLE; n = n + 1'b1;
              end
            end else begin
              b[n] = {2'b00, clu_base_r[13:8]}; n = n + 1'b1;
              b[n] = clu_base_r[7:0]; n = n + 1'b1;
              b[n] = {1'b0, clu_map_r}; n = n + 1'b1;
            end
          end
          b[n] = BYTE_TRAILER | {4'h0, trailer_flags}; n = n + 1'b1;
          b[n] = BYTE_IDLE; n = n + 1'b1;
          if (inner_barrel) begin
            b[n] = BYTE_IDLE; n = n + 1'b1;
          end
        end else begin
          b[n] = BYTE_EMPTY | {4'h0, chip_id}; n = n + 1'b1;
          b[n] = ts_v; n = n + 1'b1;
          b[n] = BYTE_IDLE; n = n + 1'b1;
        end
        // frame closes: back to reset state
        frame_open_nxt  = 1'b0;
        chip_sent_nxt   = 1'b0;
        region_sent_nxt = 1'b0;
        cur_region_nxt  = 5'd0;
        clu_valid_nxt   = 1'b0;
        clu_base_nxt    = 14'd0;
        clu_map_nxt     = 7'd0;
        frame_ts_nxt    = 8'd0;
      end
      MODE_BUSY_ON: begin
        b[n] = BYTE_BUSY_ON; n = n + 1'b1;
      end
      MODE_BUSY_OFF: begin
        b[n] = BYTE_BUSY_OFF; n = n + 1'b1;
      end
      MODE_IDLE: begin
        b[n] = BYTE_IDLE; n = n + 1'b1;
      end
      default: begin
      end
    endcase

    cmd.bytes = b;
    cmd.cnt   = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r  <= 1'b0;
      chip_sent_r   <= 1'b0;
      region_sent_r <= 1'b0;
      cur_region_r  <= 5'd0;
      clu_valid_r   <= 1'b0;
      clu_base_r    <= 14'd0;
      clu_map_r     <= 7'd0;
      frame_ts_r    <= 8'd0;
    end else if (accept) begin
      frame_open_r  <= frame_open_nxt;
      chip_sent_r   <= chip_sent_nxt;
      region_sent_r <= region_sent_nxt;
      cur_region_r  <= cur_region_nxt;
      clu_valid_r   <= clu_valid_nxt;
      clu_base_r    <= clu_base_nxt;
      clu_map_r     <= clu_map_nxt;
      frame_ts_r    <= frame_ts_nxt;
    end
  end

endmodule

/* rtl/phcf_queue.sv */
// ----------------------------------------------------------------------------
// phcf_queue: command queue
// Short FIFO of byte commands between the front end and the emitter.
// ----------------------------------------------------------------------------
module phcf_queue import phcf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic q_valid,
  output logic q_full
);

  cmd_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r,    cnt_nxt;

  assign head    = mem_r[rd_ptr_r];
  assign q_valid = (cnt_r != '0);
  assign q_full  = (cnt_r == Q_CNT_W'(Q_DEPTH));

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* rtl/phcf_back.sv */
// ----------------------------------------------------------------------------
// phcf_back: byte emitter
// Walks the head command one byte per cycle into the output register while out_stall is low.
// ----------------------------------------------------------------------------
module phcf_back import phcf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       head,
  input  logic       q_valid,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic [CNT_W-1:0] idx_r,   idx_nxt;
  logic             valid_r, valid_nxt;
  logic [7:0]       byte_r,  byte_nxt;
  logic             last_r,  last_nxt;
  logic             load;
  logic             at_end;

  assign load   = !valid_r || !out_stall;
  assign at_end = (idx_r == head.cnt - 1'b1);
  assign pop    = load && q_valid && at_end;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = q_valid;
      if (q_valid) begin
        byte_nxt = head.bytes[idx_r];
        last_nxt = at_end;
        idx_nxt  = at_end ? '0 : idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

endmodule

/* rtl/pixel_hit_cluster_framer.sv */
// ----------------------------------------------------------------------------
// pixel_hit_cluster_framer: pixel hit clustering and frame byte stream
// Groups ordered pixel hits into clusters and frames them as a byte stream.
// ----------------------------------------------------------------------------
// Usage: each input transaction is taken by the front end while in_stall is
// low; it updates frame and cluster state and queues the bytes it releases
// (0 to 9). The emitter drives one byte per cycle while out_stall is low;
// a hit that joins the open cluster, an out-of-order hit or an unused mode
// releases nothing. Sustained throughput is set by the byte output port:
// one byte per clock while out_stall is low.
// A two-entry command queue lets the front end keep accepting while the
// emitter drains, and in_stall rises only when that queue is full. Write the
// configuration registers only while the block is idle.
// ----------------------------------------------------------------------------
module pixel_hit_cluster_framer import phcf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_wdata,
  // input transactions
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [4:0]  in_region_id,
  input  logic [13:0] in_hit_position,
  input  logic [7:0]  in_timestamp,
  input  logic [3:0]  in_trailer_flags,
  // output byte transactions
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  logic [3:0] chip_id_r;
  logic       inner_barrel_r;

  logic       in_accept;
  cmd_t       cmd;
  logic       cmd_push;
  cmd_t       head;
  logic       q_valid;
  logic       q_full;
  logic       q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_id_r      <= 4'd0;
      inner_barrel_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHIP_ID:      chip_id_r      <= cfg_wdata;
        REG_INNER_BARREL: inner_barrel_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // the front end stalls only on a full command queue
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;
  // transactions that release no bytes leave no queue entry
  assign cmd_push  = in_accept && (cmd.cnt != '0);

  phcf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .chip_id       (chip_id_r),
    .inner_barrel  (inner_barrel_r),
    .accept        (in_accept),
    .mode          (in_mode),
    .region_id     (in_region_id),
    .hit_position  (in_hit_position),
    .timestamp     (in_timestamp),
    .trailer_flags (in_trailer_flags),
    .cmd           (cmd)
  );

  phcf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd),
    .pop      (q_pop),
    .head     (head),
    .q_valid  (q_valid),
    .q_full   (q_full)
  );

  phcf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_valid   (q_valid),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

`ifndef SYNTHESIS
  // a queued command always carries between one and the maximum byte count
  a_cmd_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> (cmd.cnt != '0 && cmd.cnt <= CNT_W'(CMD_BYTES)))
    else $error("queued command with bad byte count");

  // retiring a command puts its final byte in the output register
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid && out_last))
    else $error("command retired without last byte");

  // never retire from an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty command queue");
`endif

endmodule
